// ----- hdl/rvid_pkg.sv -----
// Shared types and encodings for the RV32I instruction decoder.
package rvid_pkg;

	// Major opcode field values (instruction bits 6:0).
	localparam logic [6:0] OPC_LUI    = 7'h37;
	localparam logic [6:0] OPC_AUIPC  = 7'h17;
	localparam logic [6:0] OPC_JAL    = 7'h6f;
	localparam logic [6:0] OPC_JALR   = 7'h67;
	localparam logic [6:0] OPC_BRANCH = 7'h63;
	localparam logic [6:0] OPC_LOAD   = 7'h03;
	localparam logic [6:0] OPC_STORE  = 7'h23;
	localparam logic [6:0] OPC_ALUI   = 7'h13;
	localparam logic [6:0] OPC_ALUR   = 7'h33;
	localparam logic [6:0] OPC_FENCE  = 7'h0f;
	localparam logic [6:0] OPC_SYSTEM = 7'h73;

	// Exact encoding of ecall and the upper-immediate mask.
	localparam logic [31:0] ECALL_WORD = 32'h0000_0073;
	localparam logic [31:0] UIMM_MASK  = 32'hffff_f000;

	// funct7 values used by shifts and sub/sra.
	localparam logic [6:0] F7_BASE = 7'h00;
	localparam logic [6:0] F7_ALT  = 7'h20;

	// funct3 values that need a name.
	localparam logic [2:0] F3_ZERO = 3'd0;
	localparam logic [2:0] F3_SLL  = 3'd1;
	localparam logic [2:0] F3_SLT  = 3'd2;
	localparam logic [2:0] F3_SLTU = 3'd3;
	localparam logic [2:0] F3_XOR  = 3'd4;
	localparam logic [2:0] F3_SR   = 3'd5;
	localparam logic [2:0] F3_OR   = 3'd6;
	localparam logic [2:0] F3_AND  = 3'd7;

	// funct3 slots of branches, loads and stores.
	localparam logic [2:0] F3_BEQ  = 3'd0;
	localparam logic [2:0] F3_BNE  = 3'd1;
	localparam logic [2:0] F3_BLT  = 3'd4;
	localparam logic [2:0] F3_BGE  = 3'd5;
	localparam logic [2:0] F3_BLTU = 3'd6;
	localparam logic [2:0] F3_BGEU = 3'd7;
	localparam logic [2:0] F3_LB   = 3'd0;
	localparam logic [2:0] F3_LH   = 3'd1;
	localparam logic [2:0] F3_LW   = 3'd2;
	localparam logic [2:0] F3_LBU  = 3'd4;
	localparam logic [2:0] F3_LHU  = 3'd5;
	localparam logic [2:0] F3_SB   = 3'd0;
	localparam logic [2:0] F3_SH   = 3'd1;
	localparam logic [2:0] F3_SW   = 3'd2;

	// Operation numbers.
	typedef enum logic [5:0] {
		OP_ILLEGAL = 6'd0,
		OP_LUI, OP_AUIPC, OP_JAL, OP_JALR,
		OP_BEQ, OP_BNE, OP_BLT, OP_BGE, OP_BLTU, OP_BGEU,
		OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU,
		OP_SB, OP_SH, OP_SW,
		OP_ADDI, OP_SLTI, OP_SLTIU, OP_XORI, OP_ORI, OP_ANDI,
		OP_SLLI, OP_SRLI, OP_SRAI,
		OP_ADD, OP_SLL, OP_SLT, OP_SLTU, OP_XOR, OP_SRL, OP_OR, OP_AND,
		OP_SUB, OP_SRA,
		OP_FENCE, OP_ECALL
	} op_t;

	// Operation classes.
	typedef enum logic [2:0] {
		CLS_ILLEGAL = 3'd0,
		CLS_ALU     = 3'd1,
		CLS_JUMP    = 3'd2,
		CLS_BRANCH  = 3'd3,
		CLS_LOAD    = 3'd4,
		CLS_STORE   = 3'd5,
		CLS_FENCE   = 3'd6,
		CLS_SYSTEM  = 3'd7
	} cls_t;

	// One decoded instruction.
	typedef struct packed {
		op_t                op_code;
		cls_t               op_class;
		logic [4:0]         dest_reg;
		logic [4:0]         src1_reg;
		logic [4:0]         src2_reg;
		logic signed [31:0] immediate;
	} dec_t;

endpackage

// ----- hdl/rvid_decode.sv -----
// Combinational RV32I decode of one instruction word.
module rvid_decode
	import rvid_pkg::*;
(
	input  logic [31:0] instruction,
	output dec_t        dec
);

	logic [6:0]  opc;
	logic [4:0]  rd;
	logic [2:0]  f3;
	logic [4:0]  rs1;
	logic [4:0]  rs2;
	logic [6:0]  f7;
	logic [31:0] imm_i;
	logic [31:0] imm_s;
	logic [31:0] imm_b;
	logic [31:0] imm_j;
	logic [31:0] imm_u;
	logic [31:0] imm_sh;

	// Field extraction and immediate formats.
	always_comb begin
		opc    = instruction[6:0];
		rd     = instruction[11:7];
		f3     = instruction[14:12];
		rs1    = instruction[19:15];
		rs2    = instruction[24:20];
		f7     = instruction[31:25];
		imm_i  = {{20{instruction[31]}}, instruction[31:20]};
		imm_s  = {{20{instruction[31]}}, instruction[31:25], instruction[11:7]};
		imm_b  = {{19{instruction[31]}}, instruction[31], instruction[7],
			instruction[30:25], instruction[11:8], 1'b0};
		imm_j  = {{11{instruction[31]}}, instruction[31], instruction[19:12],
			instruction[20], instruction[30:21], 1'b0};
		imm_u  = instruction & UIMM_MASK;
		imm_sh = {27'd0, rs2};
	end

	// Opcode and function-field decode; anything unrecognized stays all zero.
	always_comb begin
		dec = '0;
		if (instruction[1:0] == 2'b11) begin
			case (opc)
				OPC_LUI: begin
					dec = '{OP_LUI, CLS_ALU, rd, 5'd0, 5'd0, imm_u};
				end
				OPC_AUIPC: begin
					dec = '{OP_AUIPC, CLS_ALU, rd, 5'd0, 5'd0, imm_u};
				end
				OPC_JAL: begin
					dec = '{OP_JAL, CLS_JUMP, rd, 5'd0, 5'd0, imm_j};
				end
				OPC_JALR: begin
					if (f3 == F3_ZERO)
						dec = '{OP_JALR, CLS_JUMP, rd, rs1, 5'd0, imm_i};
				end
				OPC_BRANCH: begin
					case (f3)
						F3_BEQ:  dec = '{OP_BEQ, CLS_BRANCH, 5'd0, rs1, rs2, imm_b};
						F3_BNE:  dec = '{OP_BNE, CLS_BRANCH, 5'd0, rs1, rs2, imm_b};
						F3_BLT:  dec = '{OP_BLT, CLS_BRANCH, 5'd0, rs1, rs2, imm_b};
						F3_BGE:  dec = '{OP_BGE, CLS_BRANCH, 5'd0, rs1, rs2, imm_b};
						F3_BLTU: dec = '{OP_BLTU, CLS_BRANCH, 5'd0, rs1, rs2, imm_b};
						F3_BGEU: dec = '{OP_BGEU, CLS_BRANCH, 5'd0, rs1, rs2, imm_b};
						default: dec = '0;
					endcase
				end
				OPC_LOAD: begin
					case (f3)
						F3_LB:   dec = '{OP_LB, CLS_LOAD, rd, rs1, 5'd0, imm_i};
						F3_LH:   dec = '{OP_LH, CLS_LOAD, rd, rs1, 5'd0, imm_i};
						F3_LW:   dec = '{OP_LW, CLS_LOAD, rd, rs1, 5'd0, imm_i};
						F3_LBU:  dec = '{OP_LBU, CLS_LOAD, rd, rs1, 5'd0, imm_i};
						F3_LHU:  dec = '{OP_LHU, CLS_LOAD, rd, rs1, 5'd0, imm_i};
						default: dec = '0;
					endcase
				end
				OPC_STORE: begin
					case (f3)
						F3_SB:   dec = '{OP_SB, CLS_STORE, 5'd0, rs1, rs2, imm_s};
						F3_SH:   dec = '{OP_SH, CLS_STORE, 5'd0, rs1, rs2, imm_s};
						F3_SW:   dec = '{OP_SW, CLS_STORE, 5'd0, rs1, rs2, imm_s};
						default: dec = '0;
					endcase
				end
				OPC_ALUI: begin
					case (f3)
						F3_ZERO: dec = '{OP_ADDI, CLS_ALU, rd, rs1, 5'd0, imm_i};
						F3_SLT:  dec = '{OP_SLTI, CLS_ALU, rd, rs1, 5'd0, imm_i};
						F3_SLTU: dec = '{OP_SLTIU, CLS_ALU, rd, rs1, 5'd0, imm_i};
						F3_XOR:  dec = '{OP_XORI, CLS_ALU, rd, rs1, 5'd0, imm_i};
						F3_OR:   dec = '{OP_ORI, CLS_ALU, rd, rs1, 5'd0, imm_i};
						F3_AND:  dec = '{OP_ANDI, CLS_ALU, rd, rs1, 5'd0, imm_i};
						F3_SLL: begin
							if (f7 == F7_BASE)
								dec = '{OP_SLLI, CLS_ALU, rd, rs1, 5'd0, imm_sh};
						end
						F3_SR: begin
							if (f7 == F7_BASE)
								dec = '{OP_SRLI, CLS_ALU, rd, rs1, 5'd0, imm_sh};
							else if (f7 == F7_ALT)
								dec = '{OP_SRAI, CLS_ALU, rd, rs1, 5'd0, imm_sh};
						end
						default: dec = '0;
					endcase
				end
				OPC_ALUR: begin
					if (f7 == F7_BASE) begin
						case (f3)
							F3_ZERO: dec = '{OP_ADD, CLS_ALU, rd, rs1, rs2, 32'sd0};
							F3_SLL:  dec = '{OP_SLL, CLS_ALU, rd, rs1, rs2, 32'sd0};
							F3_SLT:  dec = '{OP_SLT, CLS_ALU, rd, rs1, rs2, 32'sd0};
							F3_SLTU: dec = '{OP_SLTU, CLS_ALU, rd, rs1, rs2, 32'sd0};
							F3_XOR:  dec = '{OP_XOR, CLS_ALU, rd, rs1, rs2, 32'sd0};
							F3_SR:   dec = '{OP_SRL, CLS_ALU, rd, rs1, rs2, 32'sd0};
							F3_OR:   dec = '{OP_OR, CLS_ALU, rd, rs1, rs2, 32'sd0};
							F3_AND:  dec = '{OP_AND, CLS_ALU, rd, rs1, rs2, 32'sd0};
							default: dec = '0;
						endcase
					end else if (f7 == F7_ALT && f3 == F3_ZERO) begin
						dec = '{OP_SUB, CLS_ALU, rd, rs1, rs2, 32'sd0};
					end else if (f7 == F7_ALT && f3 == F3_SR) begin
						dec = '{OP_SRA, CLS_ALU, rd, rs1, rs2, 32'sd0};
					end
				end
				OPC_FENCE: begin
					if (f3 == F3_ZERO)
						dec = '{OP_FENCE, CLS_FENCE, 5'd0, 5'd0, 5'd0, 32'sd0};
				end
				OPC_SYSTEM: begin
					if (instruction == ECALL_WORD)
						dec = '{OP_ECALL, CLS_SYSTEM, 5'd0, 5'd0, 5'd0, 32'sd0};
				end
				default: begin
					dec = '0;
				end
			endcase
		end
	end

endmodule

// ----- hdl/rv32i_instruction_decoder.sv -----
// Top level of the RV32I decoder: input register, decode logic, result register.
//
//  Channel | Direction | Handshake              | Payload
//  inst    | in        | inst_valid, inst_stall | instruction, fetch_pc
//  dec     | out       | dec_valid, dec_stall   | pc_out, op_code, op_class, dest_reg,
//          |           |                        | src1_reg, src2_reg, immediate
//
// A transaction can be accepted every cycle while inst_stall is low; it is held first in
// the input register and then in the result register, from which its result is presented
// and taken.
// The decode between the two registers is a single pass of opcode and field logic.
// Reset clears both valid flags; payload registers are not reset.
// While the result register is held by dec_stall, the input register still takes one
// more transaction; inst_stall rises only when both registers are full and held.
module rv32i_instruction_decoder
	import rvid_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               inst_valid,
	output logic               inst_stall,
	input  logic [31:0]        instruction,
	input  logic [31:0]        fetch_pc,
	output logic               dec_valid,
	input  logic               dec_stall,
	output logic [31:0]        pc_out,
	output logic [5:0]         op_code,
	output logic [2:0]         op_class,
	output logic [4:0]         dest_reg,
	output logic [4:0]         src1_reg,
	output logic [4:0]         src2_reg,
	output logic signed [31:0] immediate
);

	logic        valid_s1;
	logic [31:0] instr_s1;
	logic [31:0] pc_s1;
	logic        valid_s2;
	logic [31:0] pc_s2;
	dec_t        dec_s2;
	dec_t        dec_comb;
	logic        load_s2;
	logic        accept;

	// Stage flow control.
	assign load_s2    = !valid_s2 || !dec_stall;
	assign inst_stall = valid_s1 && !load_s2;
	assign accept     = inst_valid && !inst_stall;

	// Valid flags of both stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (accept)
				valid_s1 <= 1'b1;
			else if (load_s2)
				valid_s1 <= 1'b0;
			if (load_s2)
				valid_s2 <= valid_s1;
		end
	end

	// Input register.
	always_ff @(posedge clk) begin
		if (accept) begin
			instr_s1 <= instruction;
			pc_s1    <= fetch_pc;
		end
	end

	rvid_decode u_decode (
		.instruction (instr_s1),
		.dec         (dec_comb)
	);

	// Result register.
	always_ff @(posedge clk) begin
		if (load_s2 && valid_s1) begin
			dec_s2 <= dec_comb;
			pc_s2  <= pc_s1;
		end
	end

	// Result outputs.
	assign dec_valid = valid_s2;
	assign pc_out    = pc_s2;
	assign op_code   = dec_s2.op_code;
	assign op_class  = dec_s2.op_class;
	assign dest_reg  = dec_s2.dest_reg;
	assign src1_reg  = dec_s2.src1_reg;
	assign src2_reg  = dec_s2.src2_reg;
	assign immediate = dec_s2.immediate;

endmodule

// ----- dv/tb_top.sv -----
// Self-checking testbench for the RV32I instruction decoder.
`timescale 1ns / 100ps

module tb_top;
	import rvid_pkg::*;

	localparam int RANDOM_ITEMS = 600;
	localparam dec_t DEC_ZERO = '0;

	// One expected transaction on the result side.
	typedef struct packed {
		logic [31:0] pc;
		dec_t        dec;
	} decoded_t;

	// One directed row; the decode is typed in only where given is set.
	typedef struct packed {
		logic [31:0] word;
		logic [31:0] pc;
		logic        given;
		dec_t        want;
	} dir_row_t;

	logic               clk;
	logic               arst_n;
	logic               inst_valid;
	logic               inst_stall;
	logic [31:0]        instruction;
	logic [31:0]        fetch_pc;
	logic               dec_valid;
	logic               dec_stall;
	logic [31:0]        pc_out;
	logic [5:0]         op_code;
	logic [2:0]         op_class;
	logic [4:0]         dest_reg;
	logic [4:0]         src1_reg;
	logic [4:0]         src2_reg;
	logic signed [31:0] immediate;

	decoded_t pending_decodes[$];
	int       accepted_cnt = 0;
	int       err_cnt = 0;
	int       burst_left = 0;
	logic     row_given;
	dec_t     row_want;
	logic     draining = 1'b0;
	int       stall_mode = 0;
	int       stall_left = 0;
	int       stall_tick = 0;

	// Directed words: field extremes, each class and the illegal corner cases.
	dir_row_t dir_tab [0:26] = '{
		// Compressed encodings and an unknown opcode.
		{32'h0000_0000, 32'h0000_0000, 1'b1, DEC_ZERO},
		{32'h0000_0001, 32'hffff_ffff, 1'b1, DEC_ZERO},
		{32'hffff_ffff, 32'h8000_0000, 1'b1, DEC_ZERO},
		{{20'hfffff, 5'd31, OPC_LUI}, 32'h0000_0004, 1'b1,
			{OP_LUI, CLS_ALU, 5'd31, 5'd0, 5'd0, 32'hffff_f000}},
		{{20'h80000, 5'd1, OPC_AUIPC}, 32'h7fff_fffc, 1'b1,
			{OP_AUIPC, CLS_ALU, 5'd1, 5'd0, 5'd0, 32'h8000_0000}},
		// Jumps: most negative and most positive offsets, jalr with a bad funct3.
		{{1'b1, 10'h000, 1'b0, 8'h00, 5'd1, OPC_JAL}, 32'h0000_1000, 1'b0, DEC_ZERO},
		{{1'b0, 10'h3ff, 1'b1, 8'hff, 5'd31, OPC_JAL}, 32'hffff_fffc, 1'b0, DEC_ZERO},
		{{12'hfff, 5'd31, F3_ZERO, 5'd1, OPC_JALR}, 32'h0000_0100, 1'b0, DEC_ZERO},
		{{12'h000, 5'd1, F3_SLL, 5'd1, OPC_JALR}, 32'h0000_0104, 1'b1, DEC_ZERO},
		// Branch with an all-ones offset, and funct3 2, which has no branch.
		{{1'b1, 6'h3f, 5'd31, 5'd30, F3_BEQ, 4'hf, 1'b1, OPC_BRANCH}, 32'h0000_0200,
			1'b0, DEC_ZERO},
		{{7'h00, 5'd2, 5'd1, F3_SLT, 5'd0, OPC_BRANCH}, 32'h0000_0204, 1'b1, DEC_ZERO},
		{{12'h800, 5'd5, F3_LW, 5'd6, OPC_LOAD}, 32'h0000_0300, 1'b0, DEC_ZERO},
		{{7'h3f, 5'd31, 5'd31, F3_SW, 5'h1f, OPC_STORE}, 32'h0000_0400, 1'b0, DEC_ZERO},
		{{7'h00, 5'd1, 5'd2, F3_SLTU, 5'd3, OPC_STORE}, 32'h0000_0404, 1'b1, DEC_ZERO},
		// Immediate ALU, shifts and a shift with a bad funct7.
		{{12'h800, 5'd31, F3_ZERO, 5'd31, OPC_ALUI}, 32'h0000_0500, 1'b0, DEC_ZERO},
		{{F7_BASE, 5'd31, 5'd1, F3_SLL, 5'd2, OPC_ALUI}, 32'h0000_0504, 1'b0, DEC_ZERO},
		{{F7_ALT, 5'd31, 5'd3, F3_SR, 5'd4, OPC_ALUI}, 32'h0000_0508, 1'b0, DEC_ZERO},
		{{F7_ALT, 5'd3, 5'd1, F3_SLL, 5'd2, OPC_ALUI}, 32'h0000_050c, 1'b1, DEC_ZERO},
		// Register ALU, including the alternate funct7 where it is not allowed.
		{{F7_ALT, 5'd31, 5'd30, F3_ZERO, 5'd29, OPC_ALUR}, 32'h0000_0600, 1'b0, DEC_ZERO},
		{{F7_ALT, 5'd1, 5'd2, F3_SR, 5'd3, OPC_ALUR}, 32'h0000_0604, 1'b0, DEC_ZERO},
		{{F7_BASE, 5'd31, 5'd31, F3_AND, 5'd31, OPC_ALUR}, 32'h0000_0608, 1'b0, DEC_ZERO},
		{{F7_ALT, 5'd1, 5'd1, F3_AND, 5'd1, OPC_ALUR}, 32'h0000_060c, 1'b1, DEC_ZERO},
		// Fence with funct3 zero only; system opcode only as the exact ecall word.
		{{4'h8, 4'hf, 4'hf, 5'd3, F3_ZERO, 5'd4, OPC_FENCE}, 32'h0000_0700, 1'b1,
			{OP_FENCE, CLS_FENCE, 5'd0, 5'd0, 5'd0, 32'd0}},
		{{12'h000, 5'd0, F3_SLL, 5'd0, OPC_FENCE}, 32'h0000_0704, 1'b1, DEC_ZERO},
		{ECALL_WORD, 32'h0000_0800, 1'b1, {OP_ECALL, CLS_SYSTEM, 5'd0, 5'd0, 5'd0, 32'd0}},
		{{12'h001, 5'd0, F3_ZERO, 5'd0, OPC_SYSTEM}, 32'h0000_0804, 1'b1, DEC_ZERO},
		{{12'h300, 5'd1, F3_SLL, 5'd2, OPC_SYSTEM}, 32'h0000_0808, 1'b1, DEC_ZERO}
	};

	rv32i_instruction_decoder dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.inst_valid  (inst_valid),
		.inst_stall  (inst_stall),
		.instruction (instruction),
		.fetch_pc    (fetch_pc),
		.dec_valid   (dec_valid),
		.dec_stall   (dec_stall),
		.pc_out      (pc_out),
		.op_code     (op_code),
		.op_class    (op_class),
		.dest_reg    (dest_reg),
		.src1_reg    (src1_reg),
		.src2_reg    (src2_reg),
		.immediate   (immediate)
	);

	// Clock with a 20 ns period.
	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// Decodes one instruction word the way the block should.
	function automatic dec_t decode_word(input logic [31:0] w);
		dec_t        d;
		op_t         op;
		cls_t        cls;
		logic [2:0]  f3;
		logic [6:0]  f7;
		logic [4:0]  rd;
		logic [4:0]  rs1;
		logic [4:0]  rs2;
		logic [31:0] imm;
		f3 = w[14:12];
		f7 = w[31:25];
		op = OP_ILLEGAL;
		cls = CLS_ILLEGAL;
		rd = w[11:7];
		rs1 = w[19:15];
		rs2 = 5'd0;
		imm = {{20{w[31]}}, w[31:20]};
		if (w[1:0] == 2'b11) begin
			case (w[6:0])
				OPC_LUI: begin
					op = OP_LUI;
					cls = CLS_ALU;
					rs1 = 5'd0;
					imm = w & UIMM_MASK;
				end
				OPC_AUIPC: begin
					op = OP_AUIPC;
					cls = CLS_ALU;
					rs1 = 5'd0;
					imm = w & UIMM_MASK;
				end
				OPC_JAL: begin
					op = OP_JAL;
					cls = CLS_JUMP;
					rs1 = 5'd0;
					imm = {{12{w[31]}}, w[19:12], w[20], w[30:21], 1'b0};
				end
				OPC_JALR: begin
					cls = CLS_JUMP;
					if (f3 == F3_ZERO) op = OP_JALR;
				end
				OPC_BRANCH: begin
					cls = CLS_BRANCH;
					rd = 5'd0;
					rs2 = w[24:20];
					imm = {{20{w[31]}}, w[7], w[30:25], w[11:8], 1'b0};
					case (f3)
						F3_BEQ:  op = OP_BEQ;
						F3_BNE:  op = OP_BNE;
						F3_BLT:  op = OP_BLT;
						F3_BGE:  op = OP_BGE;
						F3_BLTU: op = OP_BLTU;
						F3_BGEU: op = OP_BGEU;
						default: op = OP_ILLEGAL;
					endcase
				end
				OPC_LOAD: begin
					cls = CLS_LOAD;
					case (f3)
						F3_LB:   op = OP_LB;
						F3_LH:   op = OP_LH;
						F3_LW:   op = OP_LW;
						F3_LBU:  op = OP_LBU;
						F3_LHU:  op = OP_LHU;
						default: op = OP_ILLEGAL;
					endcase
				end
				OPC_STORE: begin
					cls = CLS_STORE;
					rd = 5'd0;
					rs2 = w[24:20];
					imm = {{20{w[31]}}, w[31:25], w[11:7]};
					case (f3)
						F3_SB:   op = OP_SB;
						F3_SH:   op = OP_SH;
						F3_SW:   op = OP_SW;
						default: op = OP_ILLEGAL;
					endcase
				end
				OPC_ALUI: begin
					cls = CLS_ALU;
					case (f3)
						F3_ZERO: op = OP_ADDI;
						F3_SLT:  op = OP_SLTI;
						F3_SLTU: op = OP_SLTIU;
						F3_XOR:  op = OP_XORI;
						F3_OR:   op = OP_ORI;
						F3_AND:  op = OP_ANDI;
						F3_SLL: begin
							imm = {27'd0, w[24:20]};
							if (f7 == F7_BASE) op = OP_SLLI;
						end
						default: begin
							imm = {27'd0, w[24:20]};
							if (f7 == F7_BASE) op = OP_SRLI;
							else if (f7 == F7_ALT) op = OP_SRAI;
						end
					endcase
				end
				OPC_ALUR: begin
					cls = CLS_ALU;
					rs2 = w[24:20];
					imm = 32'd0;
					if (f7 == F7_BASE) begin
						case (f3)
							F3_ZERO: op = OP_ADD;
							F3_SLL:  op = OP_SLL;
							F3_SLT:  op = OP_SLT;
							F3_SLTU: op = OP_SLTU;
							F3_XOR:  op = OP_XOR;
							F3_SR:   op = OP_SRL;
							F3_OR:   op = OP_OR;
							default: op = OP_AND;
						endcase
					end else if (f7 == F7_ALT && f3 == F3_ZERO) begin
						op = OP_SUB;
					end else if (f7 == F7_ALT && f3 == F3_SR) begin
						op = OP_SRA;
					end
				end
				OPC_FENCE: begin
					cls = CLS_FENCE;
					rd = 5'd0;
					rs1 = 5'd0;
					imm = 32'd0;
					if (f3 == F3_ZERO) op = OP_FENCE;
				end
				OPC_SYSTEM: begin
					cls = CLS_SYSTEM;
					rd = 5'd0;
					rs1 = 5'd0;
					imm = 32'd0;
					if (w == ECALL_WORD) op = OP_ECALL;
				end
				default: op = OP_ILLEGAL;
			endcase
		end
		// Anything not recognized comes out with every decoded field zero.
		d = '0;
		if (op != OP_ILLEGAL) begin
			d.op_code = op;
			d.op_class = cls;
			d.dest_reg = rd;
			d.src1_reg = rs1;
			d.src2_reg = rs2;
			d.immediate = imm;
		end
		return d;
	endfunction

	// Random word: mostly well-formed instructions, some with broken funct
	// fields, and some raw noise.
	function automatic logic [31:0] rand_word();
		logic [31:0] w;
		int          pick;
		int          sel;
		w = $urandom;
		pick = $urandom_range(0, 99);
		sel = $urandom_range(0, 10);
		if (pick < 8) return w;
		case (sel)
			0:       w[6:0] = OPC_LUI;
			1:       w[6:0] = OPC_AUIPC;
			2:       w[6:0] = OPC_JAL;
			3:       w[6:0] = OPC_JALR;
			4:       w[6:0] = OPC_BRANCH;
			5:       w[6:0] = OPC_LOAD;
			6:       w[6:0] = OPC_STORE;
			7:       w[6:0] = OPC_ALUI;
			8:       w[6:0] = OPC_ALUR;
			9:       w[6:0] = OPC_FENCE;
			default: w[6:0] = OPC_SYSTEM;
		endcase
		if (pick < 20) return w;
		// Force legal funct fields while keeping every other bit random; a system word becomes ecall.
		case (w[6:0])
			OPC_JALR, OPC_FENCE: w[14:12] = F3_ZERO;
			OPC_BRANCH: begin
				sel = $urandom_range(0, 5);
				w[14:12] = (sel < 2) ? sel[2:0] : sel[2:0] + 3'd2;
			end
			OPC_LOAD: begin
				sel = $urandom_range(0, 4);
				w[14:12] = (sel < 3) ? sel[2:0] : sel[2:0] + 3'd1;
			end
			OPC_STORE: w[14:12] = 3'($urandom_range(0, 2));
			OPC_ALUI: begin
				if (w[14:12] == F3_SLL) w[31:25] = F7_BASE;
				else if (w[14:12] == F3_SR) w[31:25] = w[30] ? F7_ALT : F7_BASE;
			end
			OPC_ALUR: begin
				if (w[30]) begin
					w[14:12] = w[12] ? F3_SR : F3_ZERO;
					w[31:25] = F7_ALT;
				end else begin
					w[31:25] = F7_BASE;
				end
			end
			OPC_SYSTEM: w = ECALL_WORD;
			default: ;
		endcase
		return w;
	endfunction

	// Prints one mismatch line and counts it.
	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t ns: %s mismatch: got %h, expected %h", $time, what, got, want);
		err_cnt++;
	endtask

	// Drives one transaction at a falling edge and holds it until it is taken.
	// Bursts of random length are separated by random gaps, which may be empty.
	task automatic send_word(input logic [31:0] w, input logic [31:0] pc, input logic given,
			input dec_t want);
		int gap;
		int target;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 32);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				inst_valid <= 1'b0;
				instruction <= $urandom;
				fetch_pc <= $urandom;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		target = accepted_cnt + 1;
		inst_valid <= 1'b1;
		instruction <= w;
		fetch_pc <= pc;
		row_given <= given;
		row_want <= want;
		do @(negedge clk); while (accepted_cnt != target);
	endtask

	// Result checking first, then the prediction for a newly accepted transaction.
	always @(posedge clk) begin
		decoded_t exp_dec;
		if (arst_n) begin
			if (dec_valid && !dec_stall) begin
				if (pending_decodes.size() == 0) begin
					report_mismatch("unexpected transaction, pc_out", pc_out, 32'd0);
				end else begin
					exp_dec = pending_decodes.pop_front();
					if (pc_out !== exp_dec.pc)
						report_mismatch("pc_out", pc_out, exp_dec.pc);
					if (op_code !== exp_dec.dec.op_code)
						report_mismatch("op_code", 32'(op_code), 32'(exp_dec.dec.op_code));
					if (op_class !== exp_dec.dec.op_class)
						report_mismatch("op_class", 32'(op_class), 32'(exp_dec.dec.op_class));
					if (dest_reg !== exp_dec.dec.dest_reg)
						report_mismatch("dest_reg", 32'(dest_reg), 32'(exp_dec.dec.dest_reg));
					if (src1_reg !== exp_dec.dec.src1_reg)
						report_mismatch("src1_reg", 32'(src1_reg), 32'(exp_dec.dec.src1_reg));
					if (src2_reg !== exp_dec.dec.src2_reg)
						report_mismatch("src2_reg", 32'(src2_reg), 32'(exp_dec.dec.src2_reg));
					if (immediate !== exp_dec.dec.immediate)
						report_mismatch("immediate", immediate, exp_dec.dec.immediate);
				end
			end
			if (inst_valid && !inst_stall) begin
				exp_dec.pc = fetch_pc;
				exp_dec.dec = row_given ? row_want : decode_word(instruction);
				pending_decodes.push_back(exp_dec);
				accepted_cnt++;
			end
		end
	end

	// Result-side stall: phases of no stall, light, heavy and periodic stall.
	always @(negedge clk) begin
		stall_tick++;
		if (!arst_n || draining) begin
			dec_stall <= 1'b0;
		end else begin
			if (stall_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				stall_left = $urandom_range(16, 96);
			end
			stall_left--;
			case (stall_mode)
				0:       dec_stall <= 1'b0;
				1:       dec_stall <= ($urandom_range(0, 3) == 0);
				2:       dec_stall <= ($urandom_range(0, 3) != 0);
				default: dec_stall <= ((stall_tick % 5) < 2);
			endcase
		end
	end

	// Reset, directed table, random transactions, then drain and verdict.
	initial begin
		arst_n = 1'b0;
		inst_valid = 1'b0;
		instruction = 32'd0;
		fetch_pc = 32'd0;
		dec_stall = 1'b0;
		row_given = 1'b0;
		row_want = DEC_ZERO;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		foreach (dir_tab[i])
			send_word(dir_tab[i].word, dir_tab[i].pc, dir_tab[i].given, dir_tab[i].want);
		for (int n = 0; n < RANDOM_ITEMS; n++)
			send_word(rand_word(), $urandom, 1'b0, DEC_ZERO);
		inst_valid <= 1'b0;
		while (pending_decodes.size() != 0) @(negedge clk);
		draining = 1'b1;
		repeat (8) @(negedge clk);
		if (err_cnt == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#5_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule
